### rtl/core/sjf_pkg.sv
// ----------------------------------------------------------------------------
// Shortest-job-first selector package
// Shared sizes, codes, entry layout and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sjf_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int CMD_W    = 1;
   localparam int TAG_W    = 8;
   localparam int BURST_W  = 16;
   localparam int STAMP_W  = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 1'b0,
      CMD_DISPATCH = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_INSERTED   = 2'd0,
      STS_DISPATCHED = 2'd1,
      STS_EMPTY      = 2'd2,
      STS_FULL       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SCAN,
      S_DRAIN,
      S_TAKE,
      S_DONE
   } state_type;

   // One stored job
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [BURST_W-1:0] burst;
      logic [STAMP_W-1:0] arrival;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Sequencer to compare unit
   typedef struct packed {
      logic clear;   // start a new search
      logic live;    // read data belongs to a valid entry
   } best_ctl_type;

endpackage

`default_nettype wire

### rtl/core/sjf_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjf_req_if;
   import sjf_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [TAG_W-1:0]   job_tag;
   logic [BURST_W-1:0] job_burst;

   modport source (output valid, command, job_tag, job_burst, input ready);
   modport sink   (input valid, command, job_tag, job_burst, output ready);
endinterface

`default_nettype wire

### rtl/core/sjf_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjf_rsp_if;
   import sjf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TAG_W-1:0]    out_tag;
   logic [BURST_W-1:0]  out_burst;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_tag, out_burst, occupancy, input ready);
   modport sink   (input valid, status, out_tag, out_burst, occupancy, output ready);
endinterface

`default_nettype wire

### rtl/core/sjf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/sjf_best.sv
// ----------------------------------------------------------------------------
// Shortest-job compare unit
// Takes one table entry per cycle and keeps the best candidate so far.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_best (
   input  logic                        clock,
   input  logic                        reset,
   input  sjf_pkg::best_ctl_type       ctl,
   input  logic [sjf_pkg::IDX_W-1:0]   rd_idx,
   input  sjf_pkg::entry_type          rd_entry,
   input  logic [sjf_pkg::STAMP_W-1:0] stamp,
   output logic                        found,
   output logic [sjf_pkg::IDX_W-1:0]   best_idx,
   output sjf_pkg::entry_type          best_entry
);
   import sjf_pkg::*;

   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   entry_type          entry_ff, entry_in;
   logic [STAMP_W-1:0] age_ff, age_in;
   logic [STAMP_W-1:0] age;
   logic               take;

   // Age wraps with the arrival counter; older wins a burst tie.
   // Strict compares keep the lowest slot on a full tie (ascending scan).
   always_comb begin
      age  = stamp - rd_entry.arrival;
      take = ctl.live &&
             (!found_ff ||
              (rd_entry.burst < entry_ff.burst) ||
              ((rd_entry.burst == entry_ff.burst) && (age > age_ff)));
   end

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      entry_in = entry_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = rd_idx;
         entry_in = rd_entry;
         age_in   = age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      entry_ff <= entry_in;
      age_ff   <= age_in;
   end

   assign found      = found_ff;
   assign best_idx   = idx_ff;
   assign best_entry = entry_ff;

endmodule

`default_nettype wire

### rtl/core/shortest_job_first_selector.sv
// ----------------------------------------------------------------------------
// Shortest-job-first selector
// Job table with insert and dispatch-shortest commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one command per transaction: insert (job_tag, job_burst)
//   or dispatch. rsp_port returns exactly one result per command: status,
//   dispatched tag and burst (zero unless dispatched) and the table occupancy
//   after the command.
//   An insert into a full table or a dispatch from an empty table goes
//   straight to the result. An insert walks the valid bits one slot per
//   cycle to the lowest free slot. A dispatch streams every slot through
//   the job RAM read port and a single comparator, one entry per cycle.
//   One command is in flight at a time; req_port.ready is high only while
//   the sequencer is idle. The result sits in an output register; a new
//   command is accepted while it waits, and a stalled receiver only holds
//   the next result back.
//   Synchronous reset empties the table (valid bits cleared), zeroes the
//   arrival counter and drops any pending result. Job RAM contents are not
//   cleared; only valid slots are ever compared.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_job_first_selector (
   input  logic      clock,
   input  logic      reset,
   sjf_req_if.sink   req_port,
   sjf_rsp_if.source rsp_port
);
   import sjf_pkg::*;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [BURST_W-1:0]     burst_ff, burst_in;
   logic                   live_ff, live_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;

   // Result waiting to go into the output register
   status_type         res_status_ff, res_status_in;
   logic [TAG_W-1:0]   res_tag_ff, res_tag_in;
   logic [BURST_W-1:0] res_burst_ff, res_burst_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [BURST_W-1:0]  rsp_burst_ff, rsp_burst_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic         accept;
   logic         is_dispatch;
   logic         table_full;
   logic         table_empty;
   logic         slot_free;
   logic         last_idx;
   logic         out_free;
   logic         ram_we;
   logic         ram_re;
   entry_type    wr_entry;
   entry_type    rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   best_ctl_type best_ctl;
   logic         best_found;
   logic [IDX_W-1:0] best_idx;
   entry_type    best_entry;

   // Status decode
   always_comb begin
      accept      = req_port.valid && req_port.ready;
      is_dispatch = (cmd_type'(req_port.command) == CMD_DISPATCH);
      table_full  = (count_ff == CNT_W'(TABLE_DEPTH));
      table_empty = (count_ff == '0);
      slot_free   = !valid_ff[idx_ff];
      last_idx    = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
      out_free    = !rsp_valid_ff || rsp_port.ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_dispatch) begin
                  state_in = table_empty ? S_DONE : S_SCAN;
               end else begin
                  state_in = table_full ? S_DONE : S_FIND;
               end
            end
         end
         S_FIND: begin
            if (slot_free) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (last_idx) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_TAKE;
         S_TAKE:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_port.ready = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      best_ctl.clear = 1'b0;
      best_ctl.live  = live_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_port.ready = 1'b1;
            best_ctl.clear = 1'b1;
         end
         S_FIND:  ram_we = slot_free;
         S_SCAN:  ram_re = 1'b1;
         S_DRAIN, S_TAKE, S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      tag_in        = tag_ff;
      burst_in      = burst_ff;
      live_in       = ram_re && valid_ff[idx_ff];
      rd_idx_in     = idx_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_burst_in  = res_burst_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_burst_in  = rsp_burst_ff;
      rsp_occ_in    = rsp_occ_ff;

      // Command capture; early-out results for full and empty tables
      if (accept) begin
         idx_in       = '0;
         tag_in       = req_port.job_tag;
         burst_in     = req_port.job_burst;
         res_tag_in   = '0;
         res_burst_in = '0;
         res_status_in = is_dispatch ? STS_EMPTY : STS_FULL;
      end

      // Lowest free slot search and write
      if (state_ff == S_FIND) begin
         if (slot_free) begin
            valid_in[idx_ff] = 1'b1;
            count_in         = count_ff + CNT_W'(1);
            stamp_in         = stamp_ff + STAMP_W'(1);
            res_status_in    = STS_INSERTED;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      // Read stream for the compare unit
      if (ram_re) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // Remove the winner; a dispatch only gets here with a non-empty table
      if ((state_ff == S_TAKE) && best_found) begin
         valid_in[best_idx] = 1'b0;
         count_in           = count_ff - CNT_W'(1);
         res_status_in      = STS_DISPATCHED;
         res_tag_in         = best_entry.tag;
         res_burst_in       = best_entry.burst;
      end

      // Hand result to the output register
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_tag_in    = res_tag_ff;
         rsp_burst_in  = res_burst_ff;
         rsp_occ_in    = OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         stamp_ff     <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         stamp_ff     <= stamp_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      tag_ff        <= tag_in;
      burst_ff      <= burst_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_burst_ff  <= res_burst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_burst_ff  <= rsp_burst_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Job storage
   always_comb begin
      wr_entry.tag     = tag_ff;
      wr_entry.burst   = burst_ff;
      wr_entry.arrival = stamp_ff;
      rd_entry         = entry_type'(rd_word);
   end

   sjf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   // Shared comparator
   sjf_best u_best (
      .clock      (clock),
      .reset      (reset),
      .ctl        (best_ctl),
      .rd_idx     (rd_idx_ff),
      .rd_entry   (rd_entry),
      .stamp      (stamp_ff),
      .found      (best_found),
      .best_idx   (best_idx),
      .best_entry (best_entry)
   );

   // Output channel
   always_comb begin
      rsp_port.valid     = rsp_valid_ff;
      rsp_port.status    = rsp_status_ff;
      rsp_port.out_tag   = rsp_tag_ff;
      rsp_port.out_burst = rsp_burst_ff;
      rsp_port.occupancy = rsp_occ_ff;
   end

endmodule

`default_nettype wire

### rtl/core/sjf_chk.sv
// ----------------------------------------------------------------------------
// Shortest-job-first selector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sjf_pkg::STATUS_W-1:0] status,
   input logic [sjf_pkg::TAG_W-1:0]    out_tag,
   input logic [sjf_pkg::BURST_W-1:0]  out_burst,
   input logic [sjf_pkg::OCC_W-1:0]    occupancy
);
   import sjf_pkg::*;

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // One command at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command accepted while busy");

   // Only a dispatch returns a job
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != STS_DISPATCHED) |-> (out_tag == '0) && (out_burst == '0))
      else $error("job payload on non-dispatch result");

   // Empty report agrees with occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STS_EMPTY) |-> (occupancy == '0))
      else $error("empty status with nonzero occupancy");

endmodule

bind shortest_job_first_selector sjf_chk u_sjf_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .status    (rsp_port.status),
   .out_tag   (rsp_port.out_tag),
   .out_burst (rsp_port.out_burst),
   .occupancy (rsp_port.occupancy)
);

`default_nettype wire
